FILE: sv/mpd_pkg.sv
package mpd_pkg;

  // Number of pulse slots in one frame.
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
  localparam int SLOT_POS_W = $clog2(SLOT_COUNT + 1);

  // Configuration register indexes.
  localparam logic [2:0] REG_VALID_MIN = 3'd0;
  localparam logic [2:0] REG_VALID_MAX = 3'd1;
  localparam logic [2:0] REG_START_MIN = 3'd2;
  localparam logic [2:0] REG_START_MAX = 3'd3;
  localparam logic [2:0] REG_TIMEOUT   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [15:0] VALID_MIN_RESET = 16'd700;
  localparam logic [15:0] VALID_MAX_RESET = 16'd2200;
  localparam logic [15:0] START_MIN_RESET = 16'd850;
  localparam logic [15:0] START_MAX_RESET = 16'd980;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd5000;

  // Item kinds.
  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] edge_time_us;
    logic [31:0] now_ms;
    logic [2:0]  read_slot;
  } in_item_t;

  typedef struct packed {
    logic        frame_start;
    logic        stored;
    logic [2:0]  stored_slot;
    logic [15:0] stored_width;
    logic        alive;
    logic [15:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic [15:0] valid_min_us;
    logic [15:0] valid_max_us;
    logic [15:0] start_min_us;
    logic [15:0] start_max_us;
    logic [15:0] timeout_ms;
  } cfg_t;

endpackage

FILE: sv/mpd_regs.sv
module mpd_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output mpd_pkg::cfg_t cfg
);

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.valid_min_us <= mpd_pkg::VALID_MIN_RESET;
      cfg.valid_max_us <= mpd_pkg::VALID_MAX_RESET;
      cfg.start_min_us <= mpd_pkg::START_MIN_RESET;
      cfg.start_max_us <= mpd_pkg::START_MAX_RESET;
      cfg.timeout_ms   <= mpd_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mpd_pkg::REG_VALID_MIN: cfg.valid_min_us <= cfg_data;
        mpd_pkg::REG_VALID_MAX: cfg.valid_max_us <= cfg_data;
        mpd_pkg::REG_START_MIN: cfg.start_min_us <= cfg_data;
        mpd_pkg::REG_START_MAX: cfg.start_max_us <= cfg_data;
        mpd_pkg::REG_TIMEOUT:   cfg.timeout_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/mpd_core.sv
module mpd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  mpd_pkg::in_item_t item,
  input  mpd_pkg::cfg_t     cfg,
  output mpd_pkg::out_item_t result
);

  logic [31:0] previous_edge_us;
  logic [31:0] previous_edge_us_next;
  logic [mpd_pkg::SLOT_POS_W-1:0] slot_position;
  logic [mpd_pkg::SLOT_POS_W-1:0] slot_position_next;
  logic [31:0] last_valid_ms;
  logic [31:0] last_valid_ms_next;
  logic [15:0] slot_widths [mpd_pkg::SLOT_COUNT];

  logic [31:0] gap;
  logic        is_edge;
  logic        gap_valid;
  logic        gap_start;
  logic        do_store;
  logic [mpd_pkg::SLOT_IDX_W-1:0] wr_idx;
  logic [31:0] since_valid;
  logic [15:0] rd_word;

  // Gap classification against the two windows.
  assign is_edge   = (item.kind == mpd_pkg::KIND_EDGE);
  assign gap       = item.edge_time_us - previous_edge_us;
  assign gap_valid = (gap > {16'd0, cfg.valid_min_us}) && (gap < {16'd0, cfg.valid_max_us});
  assign gap_start = (gap > {16'd0, cfg.start_min_us}) && (gap < {16'd0, cfg.start_max_us});
  assign do_store  = is_edge && gap_valid && !gap_start &&
                     (32'(slot_position) < mpd_pkg::SLOT_COUNT);
  assign wr_idx    = slot_position[mpd_pkg::SLOT_IDX_W-1:0];

  // Next state of the position, timestamps and last valid time.
  always_comb begin
    slot_position_next    = slot_position;
    last_valid_ms_next    = last_valid_ms;
    previous_edge_us_next = previous_edge_us;
    if (is_edge) begin
      previous_edge_us_next = item.edge_time_us;
      if (gap_valid && gap_start) begin
        slot_position_next = '0;
      end else if (do_store) begin
        slot_position_next = slot_position + 1'b1;
        last_valid_ms_next = item.now_ms;
      end
    end
  end

  // Slot read, with the write of this item forwarded.
  always_comb begin
    rd_word = slot_widths[item.read_slot];
    if (do_store && (wr_idx == item.read_slot)) begin
      rd_word = gap[15:0];
    end
  end

  assign since_valid = item.now_ms - last_valid_ms_next;

  // Result of the current item.
  always_comb begin
    result.frame_start  = is_edge && gap_valid && gap_start;
    result.stored       = do_store;
    result.stored_slot  = do_store ? 3'(wr_idx) : 3'd0;
    result.stored_width = do_store ? gap[15:0] : 16'd0;
    result.alive        = (since_valid < {16'd0, cfg.timeout_ms});
    result.read_value   = (32'(item.read_slot) < mpd_pkg::SLOT_COUNT) ? rd_word : 16'd0;
  end

  // State registers, updated once per item that moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_edge_us <= '0;
      slot_position    <= mpd_pkg::SLOT_POS_W'(mpd_pkg::SLOT_COUNT);
      last_valid_ms    <= '0;
      for (int i = 0; i < mpd_pkg::SLOT_COUNT; i++) begin
        slot_widths[i] <= '0;
      end
    end else if (step) begin
      previous_edge_us <= previous_edge_us_next;
      slot_position    <= slot_position_next;
      last_valid_ms    <= last_valid_ms_next;
      if (do_store) begin
        slot_widths[wr_idx] <= gap[15:0];
      end
    end
  end

  // The position never passes the slot count.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    32'(slot_position) <= mpd_pkg::SLOT_COUNT)
    else $error("slot position beyond slot count");

  // A stored gap advances the position by one.
  a_store_advance: assert property (@(posedge clk) disable iff (rst)
    (step && do_store) |=> (slot_position == $past(slot_position) + 1'b1))
    else $error("store did not advance position");

  // A start pulse rewinds the position.
  a_start_rewind: assert property (@(posedge clk) disable iff (rst)
    (step && result.frame_start) |=> (slot_position == '0))
    else $error("start pulse did not rewind position");

  // A status item leaves the state untouched.
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    (step && !is_edge) |=> ($stable(previous_edge_us) && $stable(slot_position) &&
                            $stable(last_valid_ms)))
    else $error("status item changed state");

endmodule

FILE: sv/multiswitch_pulse_train_decoder.sv
// Channel  | Handshake                 | Payload
// item     | item_valid / item_ready   | item_data (mpd_pkg::in_item_t)
// result   | result_valid / result_ready | result_data (mpd_pkg::out_item_t)
// config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// The result is offered once its item has passed the input register and the
// decode and state update have loaded the result register.
// One item is accepted per cycle while the result is not stalled; the state
// update of an item is ready in time for the one behind it. Synchronous
// reset restores the register defaults, clears all slots and waits for a
// start pulse. A stalled result holds both stages, and input is refused
// only while both are full.
module multiswitch_pulse_train_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  mpd_pkg::in_item_t  item_data,
  output logic               result_valid,
  input  logic               result_ready,
  output mpd_pkg::out_item_t result_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  mpd_pkg::cfg_t      cfg;
  mpd_pkg::in_item_t  hold_item;
  logic               hold_valid;
  logic               advance;
  mpd_pkg::out_item_t core_result;

  assign cfg_ready = 1'b1;

  mpd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held item moves on when the result register is free.
  assign advance    = hold_valid && (!result_valid || result_ready);
  assign item_ready = !hold_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      hold_item <= item_data;
    end
  end

  mpd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold_item),
    .cfg    (cfg),
    .result (core_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_data <= core_result;
    end
  end

endmodule
